// ===== rtl/core/rcp_pkg.sv =====
// Package for the RIFF/WAVE chunk parser core.
// Holds chunk tags, byte kinds, error codes and shared structs; no dependencies.
`default_nettype none
package rcp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam int unsigned FMT_BYTES = 16;

	typedef enum logic [2:0] {
		KIND_HEADER    = 3'd0,
		KIND_CTYPE     = 3'd1,
		KIND_FORMAT    = 3'd2,
		KIND_PAYLOAD   = 3'd3,
		KIND_SKIPPED   = 3'd4,
		KIND_PAD       = 3'd5,
		KIND_IGNORED   = 3'd6
	} kind_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ERR_OVER_FILE = 3'd2;
	localparam logic [2:0] ERR_CHILD_BIG = 3'd3;
	localparam logic [2:0] ERR_MISPLACED = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_ALAW  = 16'd6;
	localparam logic [15:0] FMT_MULAW = 16'd7;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [15:0] bits;
	} fmt_t;

	typedef struct packed {
		logic       step;
		logic [7:0] in_byte;
		logic       last;
		logic [31:0] limit;
	} step_t;

endpackage
`default_nettype wire

// ===== rtl/core/rcp_fmt_decode.sv =====
// Format field decode: decode type and codec support from the captured fmt words.
// Depends on rcp_pkg.
`default_nettype none
module rcp_fmt_decode (
	input  rcp_pkg::fmt_t fmt,
	output logic [15:0]   decode_type,
	output logic          codec_supported
);
	import rcp_pkg::*;

	always_comb begin
		if (fmt.tag == FMT_PCM) begin
			if (fmt.bits <= 16'd8) begin
				decode_type = 16'd1;
			end else if (fmt.bits <= 16'd16) begin
				decode_type = 16'd2;
			end else begin
				decode_type = 16'd0;
			end
		end else begin
			decode_type = fmt.tag;
		end
		codec_supported = ((fmt.tag == FMT_PCM) && (fmt.bits <= 16'd16)) ||
			(fmt.tag == FMT_ALAW) || (fmt.tag == FMT_MULAW);
	end

endmodule
`default_nettype wire

// ===== rtl/core/rcp_parser.sv =====
// Chunk parse state and per-byte next-state logic; classifies each stepped byte.
// Depends on rcp_pkg.
`default_nettype none
module rcp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  rcp_pkg::step_t st,
	output rcp_pkg::kind_t kind,
	output logic [2:0]    err_code,
	output logic          fmt_seen,
	output rcp_pkg::fmt_t fmt
);
	import rcp_pkg::*;

	logic [1:0]  nest_q;
	logic [3:0]  hcnt_q;
	logic [31:0] cont_q;
	logic [31:0] cl_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic        pad_q;
	logic [2:0]  err_q;
	logic [4:0]  fidx_q;
	logic        fseen_q;
	logic [7:0]  fmt_q [FMT_BYTES];

	logic [1:0]  n_nest;
	logic [3:0]  n_hcnt;
	logic [31:0] n_cont;
	logic [31:0] n_cl;
	logic [31:0] n_tag;
	logic [31:0] n_len;
	logic        n_pad;
	logic [4:0]  n_fidx;
	logic        n_fseen;
	logic        fmt_we;
	logic        fmt_clr;
	logic [2:0]  err;

	always_comb begin
		logic        fin;
		logic [32:0] total;
		fin     = 1'b0;
		total   = '0;
		n_nest  = nest_q;
		n_hcnt  = hcnt_q;
		n_cont  = cont_q;
		n_cl    = cl_q;
		n_tag   = tag_q;
		n_len   = len_q;
		n_pad   = pad_q;
		n_fidx  = fidx_q;
		n_fseen = fseen_q;
		fmt_we  = 1'b0;
		fmt_clr = 1'b0;
		err     = ERR_NONE;
		kind    = KIND_IGNORED;
		if (err_q == ERR_NONE) begin
			if (nest_q == 2'd2) begin
				if (cl_q != 32'd0) begin
					if (tag_q == TAG_FMT) begin
						kind = KIND_FORMAT;
						if (fidx_q < 5'(FMT_BYTES)) begin
							fmt_we = 1'b1;
							n_fidx = fidx_q + 5'd1;
						end
					end else if (tag_q == TAG_DATA) begin
						kind = KIND_PAYLOAD;
					end else begin
						kind = KIND_SKIPPED;
					end
					n_cl = cl_q - 32'd1;
				end else begin
					kind  = KIND_PAD;
					n_pad = 1'b0;
				end
				fin = (n_cl == 32'd0) && !n_pad;
			end else if ((nest_q == 2'd1) && (hcnt_q == 4'd0) && (cont_q < 32'd8)) begin
				kind = KIND_SKIPPED;
				if (cont_q != 32'd0) begin
					n_cont = cont_q - 32'd1;
				end
				if (n_cont == 32'd0) begin
					n_nest = 2'd0;
				end
			end else if (hcnt_q >= 4'd8) begin
				kind   = KIND_CTYPE;
				n_tag  = {tag_q[23:0], st.in_byte};
				n_hcnt = hcnt_q + 4'd1;
				if (hcnt_q == 4'd11) begin
					n_hcnt = 4'd0;
					if (n_tag != TAG_WAVE) begin
						err = ERR_NOT_WAVE;
					end else begin
						n_cont = (len_q >= 32'd4) ? len_q - 32'd4 : 32'd0;
						n_nest = (n_cont != 32'd0) ? 2'd1 : 2'd0;
					end
				end
			end else begin
				kind = KIND_HEADER;
				if (hcnt_q == 4'd0) begin
					n_tag = {24'd0, st.in_byte};
				end else if (hcnt_q < 4'd4) begin
					n_tag = {tag_q[23:0], st.in_byte};
				end else if (hcnt_q == 4'd4) begin
					n_len = {24'd0, st.in_byte};
				end else begin
					n_len[{hcnt_q[1:0], 3'b000} +: 8] = st.in_byte;
				end
				n_hcnt = hcnt_q + 4'd1;
				if (hcnt_q == 4'd7) begin
					n_hcnt = 4'd0;
					if (n_len > st.limit) begin
						err = ERR_OVER_FILE;
					end else if (nest_q == 2'd0) begin
						if (n_tag != TAG_RIFF) begin
							err = ERR_NOT_WAVE;
						end else begin
							n_hcnt = 4'd8;
						end
					end else if (n_tag == TAG_RIFF) begin
						err = ERR_MISPLACED;
					end else begin
						n_cl   = n_len;
						n_pad  = n_len[0];
						n_nest = 2'd2;
						if (n_tag == TAG_FMT) begin
							fmt_clr = 1'b1;
							n_fidx  = 5'd0;
						end
						fin = (n_len == 32'd0);
					end
				end
			end
			if (fin) begin
				n_nest = 2'd1;
				if (n_tag == TAG_FMT) begin
					n_fseen = 1'b1;
				end
				total = {1'b0, n_len} + {32'd0, n_len[0]} + 33'd8;
				if (total > {1'b0, n_cont}) begin
					n_cont = 32'd0;
					err    = ERR_CHILD_BIG;
				end else begin
					n_cont = n_cont - total[31:0];
				end
				if (n_cont == 32'd0) begin
					n_nest = 2'd0;
				end
			end
			if ((err == ERR_NONE) && st.last && (n_hcnt != 4'd0)) begin
				err = ERR_TRUNCATED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nest_q  <= 2'd0;
			hcnt_q  <= 4'd0;
			cont_q  <= 32'd0;
			cl_q    <= 32'd0;
			tag_q   <= 32'd0;
			len_q   <= 32'd0;
			pad_q   <= 1'b0;
			err_q   <= ERR_NONE;
			fidx_q  <= 5'd0;
			fseen_q <= 1'b0;
			for (int i = 0; i < FMT_BYTES; i++) begin
				fmt_q[i] <= 8'd0;
			end
		end else if (st.step) begin
			nest_q  <= n_nest;
			hcnt_q  <= n_hcnt;
			cont_q  <= n_cont;
			cl_q    <= n_cl;
			tag_q   <= n_tag;
			len_q   <= n_len;
			pad_q   <= n_pad;
			fidx_q  <= n_fidx;
			fseen_q <= n_fseen;
			if ((err_q == ERR_NONE) && (err != ERR_NONE)) begin
				err_q <= err;
			end
			if (fmt_clr) begin
				for (int i = 0; i < FMT_BYTES; i++) begin
					fmt_q[i] <= 8'd0;
				end
			end else if (fmt_we) begin
				fmt_q[fidx_q[3:0]] <= st.in_byte;
			end
		end
	end

	assign err_code  = err_q;
	assign fmt_seen  = fseen_q;
	assign fmt.tag   = {fmt_q[1], fmt_q[0]};
	assign fmt.chans = {fmt_q[3], fmt_q[2]};
	assign fmt.rate  = {fmt_q[7], fmt_q[6], fmt_q[5], fmt_q[4]};
	assign fmt.bits  = {fmt_q[15], fmt_q[14]};

endmodule
`default_nettype wire

// ===== rtl/core/riff_wave_chunk_parser_core.sv =====
// Top level of the RIFF/WAVE chunk parser: input register, parser, result register.
// Depends on rcp_pkg, rcp_parser and rcp_fmt_decode.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | in_byte, last_byte
//  out      | out_valid/out_ready  | byte_kind, data_byte, stream_ok, error_code,
//           |                      | format fields, decode_type, codec_supported
//  cfg      | cfg_valid/cfg_ready  | cfg_data (file_size_limit)
//
// One word per cycle sustained while the output is not stalled; an accepted word
// passes through the input register to the parse logic, whose result is registered.
// Reset clears all parse state; file_size_limit resets to all ones.
// A stalled output holds the parse state; the input register still takes one word.
`default_nettype none
module riff_wave_chunk_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  byte_kind,
	output logic [7:0]  data_byte,
	output logic        stream_ok,
	output logic [2:0]  error_code,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_bits,
	output logic [15:0] decode_type,
	output logic        codec_supported,
	output logic        format_seen,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import rcp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  data_q;
	logic [31:0] limit_q;
	logic        advance;
	step_t       st;
	kind_t       kind;
	logic [2:0]  err_code;
	fmt_t        fmt;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			limit_q     <= 32'hFFFF_FFFF;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
		if (advance) begin
			kind_q <= kind;
			data_q <= (kind == KIND_PAYLOAD) ? byte_s1 : 8'd0;
		end
	end

	assign st.step    = advance;
	assign st.in_byte = byte_s1;
	assign st.last    = last_s1;
	assign st.limit   = limit_q;

	rcp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.kind     (kind),
		.err_code (err_code),
		.fmt_seen (format_seen),
		.fmt      (fmt)
	);

	rcp_fmt_decode u_decode (
		.fmt             (fmt),
		.decode_type     (decode_type),
		.codec_supported (codec_supported)
	);

	assign out_valid     = out_valid_q;
	assign byte_kind     = kind_q;
	assign data_byte     = data_q;
	assign error_code    = err_code;
	assign stream_ok     = (err_code == ERR_NONE);
	assign format_tag    = fmt.tag;
	assign channel_count = fmt.chans;
	assign sample_rate   = fmt.rate;
	assign sample_bits   = fmt.bits;

endmodule
`default_nettype wire
